FILE: hw/rtl/tss_pkg.sv
// Package for the triangle scanline span block.
// Holds the default coordinate width and the color width; no dependencies.
`default_nettype none
package tss_pkg;
  localparam int COORD_BITS = 13;
  localparam int COLOR_BITS = 32;
endpackage
`default_nettype wire

FILE: hw/rtl/tss_div.sv
// Pipelined unsigned restoring divider, one quotient bit per stage.
// Depends on tss_pkg for the default width; stage enables come from the parent.
`default_nettype none
module tss_div #(
  parameter int COORD_BITS = tss_pkg::COORD_BITS
) (
  input  wire logic                      clk,
  input  wire logic [COORD_BITS-1:0]     en,
  input  wire logic [2*COORD_BITS-1:0]   num,
  input  wire logic [COORD_BITS-1:0]     den,
  output logic      [COORD_BITS-1:0]     quo
);
  localparam int C = COORD_BITS;

  logic [2*C-1:0] rem_r [C];
  logic [C-1:0]   den_r [C];
  logic [C-1:0]   q_r   [C];

  for (genvar j = 0; j < C; j++) begin : g_stage
    localparam int I = C - 1 - j;
    logic [2*C-1:0] rem_in, shd, rem_nxt;
    logic [C-1:0]   den_in, q_in, q_nxt;

    if (j == 0) begin : g_first
      assign rem_in = num;
      assign den_in = den;
      assign q_in   = '0;
    end else begin : g_next
      assign rem_in = rem_r[j-1];
      assign den_in = den_r[j-1];
      assign q_in   = q_r[j-1];
    end

    always_comb begin
      shd     = {{C{1'b0}}, den_in} << I;
      rem_nxt = rem_in;
      q_nxt   = q_in;
      if (rem_in >= shd) begin
        rem_nxt  = rem_in - shd;
        q_nxt[I] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (en[j]) begin
        rem_r[j] <= rem_nxt;
        den_r[j] <= den_in;
        q_r[j]   <= q_nxt;
      end
    end
  end

  assign quo = q_r[C-1];
endmodule
`default_nettype wire

FILE: hw/rtl/triangle_scanline_span.sv
// Triangle scanline span. Throughput one word per cycle unless out_ready
// stalls the output; stages are sort, edge setup, multiply,
// magnitude, COORD_BITS divider stages (one quotient bit each), output.
// Any stage with a free slot advances, so bubbles close up under a stall.
// Synchronous active-low reset clears all stage valid bits.
// Depends on tss_pkg and tss_div.
`default_nettype none
module triangle_scanline_span #(
  parameter int COORD_BITS = tss_pkg::COORD_BITS
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic signed [COORD_BITS-1:0]   in_ax,
  input  wire logic signed [COORD_BITS-1:0]   in_ay,
  input  wire logic signed [COORD_BITS-1:0]   in_bx,
  input  wire logic signed [COORD_BITS-1:0]   in_by,
  input  wire logic signed [COORD_BITS-1:0]   in_cx_in,
  input  wire logic signed [COORD_BITS-1:0]   in_cy_in,
  input  wire logic signed [COORD_BITS-1:0]   in_row,
  input  wire logic [tss_pkg::COLOR_BITS-1:0] in_fill_color,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic                                out_span_valid,
  output logic signed [COORD_BITS-1:0]        out_span_left,
  output logic signed [COORD_BITS-1:0]        out_span_right,
  output logic signed [COORD_BITS-1:0]        out_span_row,
  output logic [tss_pkg::COLOR_BITS-1:0]      out_span_color
);
  localparam int C    = COORD_BITS;
  localparam int D    = C + 1;
  localparam int NDIV = C;
  localparam int NST  = NDIV + 5;
  localparam int SDV  = 4;

  typedef struct packed {
    logic signed [C-1:0] x1, y1, x2, y2, x3, y3, r;
    logic [tss_pkg::COLOR_BITS-1:0] color;
  } srt_t;

  typedef struct packed {
    logic ok;
    logic signed [C-1:0] row;
    logic [tss_pkg::COLOR_BITS-1:0] color;
  } ctl_t;

  typedef struct packed {
    logic signed [C-1:0] x0;
    logic signed [D-1:0] dx, ry, dy;
  } edg_t;

  typedef struct packed {
    logic signed [C-1:0]   x0;
    logic signed [2*D-1:0] p;
    logic signed [D-1:0]   dy;
  } prd_t;

  typedef struct packed {
    logic signed [C-1:0] x0;
    logic neg;
    logic usex0;
  } side_t;

  logic [NST-1:0] v_r, free;

  always_comb begin
    free[NST-1] = !v_r[NST-1] || out_ready;
    for (int k = NST - 2; k >= 0; k--) begin
      free[k] = !v_r[k] || free[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (free[0]) v_r[0] <= in_valid;
      for (int k = 1; k < NST; k++) begin
        if (free[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  assign in_ready = free[0];

  // stage 0: sort by y
  srt_t s0_nxt, s0_r;
  always_comb begin
    logic signed [C-1:0] t;
    t = '0;
    s0_nxt = '{x1: in_ax, y1: in_ay, x2: in_bx, y2: in_by, x3: in_cx_in,
               y3: in_cy_in, r: in_row, color: in_fill_color};
    if (s0_nxt.y1 > s0_nxt.y2) begin
      t = s0_nxt.x1; s0_nxt.x1 = s0_nxt.x2; s0_nxt.x2 = t;
      t = s0_nxt.y1; s0_nxt.y1 = s0_nxt.y2; s0_nxt.y2 = t;
    end
    if (s0_nxt.y1 > s0_nxt.y3) begin
      t = s0_nxt.x1; s0_nxt.x1 = s0_nxt.x3; s0_nxt.x3 = t;
      t = s0_nxt.y1; s0_nxt.y1 = s0_nxt.y3; s0_nxt.y3 = t;
    end
    if (s0_nxt.y2 > s0_nxt.y3) begin
      t = s0_nxt.x2; s0_nxt.x2 = s0_nxt.x3; s0_nxt.x3 = t;
      t = s0_nxt.y2; s0_nxt.y2 = s0_nxt.y3; s0_nxt.y3 = t;
    end
  end

  always_ff @(posedge clk) begin
    if (free[0]) s0_r <= s0_nxt;
  end

  // stage 1: edge setup
  ctl_t c1_nxt, c1_r;
  edg_t ea_nxt, eb_nxt, ea1_r, eb1_r;
  always_comb begin
    c1_nxt.ok    = (s0_r.y3 != s0_r.y1) && (s0_r.r >= s0_r.y1) && (s0_r.r <= s0_r.y3);
    c1_nxt.row   = s0_r.r;
    c1_nxt.color = s0_r.color;
    ea_nxt.x0 = s0_r.x1;
    ea_nxt.dx = D'(s0_r.x3) - D'(s0_r.x1);
    ea_nxt.ry = D'(s0_r.r) - D'(s0_r.y1);
    ea_nxt.dy = D'(s0_r.y3) - D'(s0_r.y1);
    if (s0_r.r < s0_r.y2) begin
      eb_nxt.x0 = s0_r.x1;
      eb_nxt.dx = D'(s0_r.x2) - D'(s0_r.x1);
      eb_nxt.ry = D'(s0_r.r) - D'(s0_r.y1);
      eb_nxt.dy = D'(s0_r.y2) - D'(s0_r.y1);
    end else begin
      eb_nxt.x0 = s0_r.x2;
      eb_nxt.dx = D'(s0_r.x3) - D'(s0_r.x2);
      eb_nxt.ry = D'(s0_r.r) - D'(s0_r.y2);
      eb_nxt.dy = D'(s0_r.y3) - D'(s0_r.y2);
    end
  end

  always_ff @(posedge clk) begin
    if (free[1]) begin
      c1_r  <= c1_nxt;
      ea1_r <= ea_nxt;
      eb1_r <= eb_nxt;
    end
  end

  // stage 2: multiply
  ctl_t c2_r;
  prd_t pa2_r, pb2_r;
  always_ff @(posedge clk) begin
    if (free[2]) begin
      c2_r     <= c1_r;
      pa2_r.x0 <= ea1_r.x0;
      pa2_r.p  <= ea1_r.dx * ea1_r.ry;
      pa2_r.dy <= ea1_r.dy;
      pb2_r.x0 <= eb1_r.x0;
      pb2_r.p  <= eb1_r.dx * eb1_r.ry;
      pb2_r.dy <= eb1_r.dy;
    end
  end

  // stage 3: magnitudes and signs
  ctl_t  c3_r;
  side_t sa3_r, sb3_r;
  logic [2*C-1:0] na3_r, nb3_r;
  logic [C-1:0]   da3_r, db3_r;
  logic signed [2*D-1:0] pa_abs, pb_abs;
  logic signed [D-1:0]   dya_abs, dyb_abs;
  always_comb begin
    pa_abs  = pa2_r.p[2*D-1] ? -pa2_r.p : pa2_r.p;
    pb_abs  = pb2_r.p[2*D-1] ? -pb2_r.p : pb2_r.p;
    dya_abs = pa2_r.dy[D-1] ? -pa2_r.dy : pa2_r.dy;
    dyb_abs = pb2_r.dy[D-1] ? -pb2_r.dy : pb2_r.dy;
  end

  always_ff @(posedge clk) begin
    if (free[3]) begin
      c3_r        <= c2_r;
      na3_r       <= pa_abs[2*C-1:0];
      nb3_r       <= pb_abs[2*C-1:0];
      da3_r       <= dya_abs[C-1:0];
      db3_r       <= dyb_abs[C-1:0];
      sa3_r.x0    <= pa2_r.x0;
      sa3_r.neg   <= pa2_r.p[2*D-1] ^ pa2_r.dy[D-1];
      sa3_r.usex0 <= (pa2_r.dy == '0);
      sb3_r.x0    <= pb2_r.x0;
      sb3_r.neg   <= pb2_r.p[2*D-1] ^ pb2_r.dy[D-1];
      sb3_r.usex0 <= (pb2_r.dy == '0);
    end
  end

  // divider stages
  logic [C-1:0] qa, qb;
  tss_div #(.COORD_BITS(C)) u_div_a (
    .clk(clk), .en(free[SDV +: NDIV]), .num(na3_r), .den(da3_r), .quo(qa)
  );
  tss_div #(.COORD_BITS(C)) u_div_b (
    .clk(clk), .en(free[SDV +: NDIV]), .num(nb3_r), .den(db3_r), .quo(qb)
  );

  ctl_t  cd_r [NDIV];
  side_t sa_r [NDIV];
  side_t sb_r [NDIV];
  always_ff @(posedge clk) begin
    if (free[SDV]) begin
      cd_r[0] <= c3_r;
      sa_r[0] <= sa3_r;
      sb_r[0] <= sb3_r;
    end
    for (int j = 1; j < NDIV; j++) begin
      if (free[SDV+j]) begin
        cd_r[j] <= cd_r[j-1];
        sa_r[j] <= sa_r[j-1];
        sb_r[j] <= sb_r[j-1];
      end
    end
  end

  // output stage: sign, offset, order
  ctl_t cl;
  side_t sal, sbl;
  logic signed [D-1:0] qsa, qsb, suma, sumb;
  logic signed [C-1:0] xa, xb, lo_nxt, hi_nxt;
  logic signed [C-1:0] lo_r, hi_r, row_r;
  logic [tss_pkg::COLOR_BITS-1:0] color_r;
  logic ok_r;
  always_comb begin
    cl   = cd_r[NDIV-1];
    sal  = sa_r[NDIV-1];
    sbl  = sb_r[NDIV-1];
    qsa  = sal.neg ? -$signed({1'b0, qa}) : $signed({1'b0, qa});
    qsb  = sbl.neg ? -$signed({1'b0, qb}) : $signed({1'b0, qb});
    suma = D'(sal.x0) + qsa;
    sumb = D'(sbl.x0) + qsb;
    xa   = sal.usex0 ? sal.x0 : suma[C-1:0];
    xb   = sbl.usex0 ? sbl.x0 : sumb[C-1:0];
    lo_nxt = '0;
    hi_nxt = '0;
    if (cl.ok) begin
      lo_nxt = (xa > xb) ? xb : xa;
      hi_nxt = (xa > xb) ? xa : xb;
    end
  end

  always_ff @(posedge clk) begin
    if (free[NST-1]) begin
      ok_r    <= cl.ok;
      lo_r    <= lo_nxt;
      hi_r    <= hi_nxt;
      row_r   <= cl.row;
      color_r <= cl.color;
    end
  end

  assign out_valid      = v_r[NST-1];
  assign out_span_valid = ok_r;
  assign out_span_left  = lo_r;
  assign out_span_right = hi_r;
  assign out_span_row   = row_r;
  assign out_span_color = color_r;
endmodule
`default_nettype wire

FILE: hw/rtl/tss_checker.sv
// Port-level checks for triangle_scanline_span, bound to the top level.
// Depends on tss_pkg for widths.
`default_nettype none
module tss_checker #(
  parameter int COORD_BITS = tss_pkg::COORD_BITS
) (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           out_valid,
  input wire logic                           out_ready,
  input wire logic                           out_span_valid,
  input wire logic signed [COORD_BITS-1:0]   out_span_left,
  input wire logic signed [COORD_BITS-1:0]   out_span_right
);
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("output word dropped while stalled");

  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_span_valid |-> out_span_left <= out_span_right)
    else $error("span ends out of order");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_span_valid |-> out_span_left == '0 && out_span_right == '0)
    else $error("empty span with nonzero ends");
endmodule

bind triangle_scanline_span tss_checker #(.COORD_BITS(COORD_BITS)) u_tss_checker (
  .clk(clk), .rst_n(rst_n), .out_valid(out_valid), .out_ready(out_ready),
  .out_span_valid(out_span_valid), .out_span_left(out_span_left),
  .out_span_right(out_span_right)
);
`default_nettype wire
